[hdl/sum_checked_packet_receiver_assert.svh]
// Assertion macros for the packet receiver checkers.
`ifndef SUM_CHECKED_PACKET_RECEIVER_ASSERT_SVH
`define SUM_CHECKED_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SCPR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SCPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/scpr_pkg.sv]
package scpr_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned FILL_W  = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // Most results a single packet may produce
  localparam int unsigned RESULT_CAP = 32;

  // Payload banks: one being filled, one being replayed
  localparam int unsigned NUM_BANKS = 2;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] START_ONE_RST = 8'd170;
  localparam logic [BYTE_W-1:0] START_TWO_RST = 8'd175;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST   = 6'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ONE = 2'd0,
    CFG_START_TWO = 2'd1,
    CFG_MAX_LEN   = 2'd2
  } scpr_cfg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHK1  = 3'd5,
    PH_CHK2  = 3'd6
  } scpr_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              timeout;
  } scpr_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] msg_id;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              has_data;
    logic              last;
  } scpr_out_t;

  // Descriptor of a packet that passed both checks
  typedef struct packed {
    logic [BYTE_W-1:0] msg_id;
    logic [LEN_W-1:0]  length;
  } scpr_desc_t;

  // Payload store write port
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [FILL_W-1:0] idx;
    logic [BYTE_W-1:0] data;
  } scpr_wr_t;

endpackage

[hdl/scpr_queue.sv]
module scpr_queue
  import scpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  scpr_desc_t push_desc,
  input  logic       pop,
  output scpr_desc_t head_desc,
  output logic       not_empty,
  output logic       full
);

  localparam int unsigned CNT_W = $clog2(NUM_BANKS + 1);

  scpr_desc_t       entry_r [NUM_BANKS];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(NUM_BANKS));
  assign head_desc = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

[hdl/scpr_front.sv]
module scpr_front
  import scpr_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_acc,
  input  scpr_in_t             in_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output scpr_wr_t             wr,
  output logic                 push,
  output scpr_desc_t           push_desc
);

  localparam int unsigned LEN_CAP =
    (PAYLOAD_DEPTH < RESULT_CAP) ? PAYLOAD_DEPTH : RESULT_CAP;

  scpr_phase_t       phase_r, phase_nxt;
  logic [BYTE_W-1:0] run_sum_r, run_sum_nxt;
  logic [BYTE_W-1:0] sos_r, sos_nxt;
  logic [BYTE_W-1:0] id_r, id_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              bank_r, bank_nxt;
  logic [BYTE_W-1:0] start_one_r, start_two_r;
  logic [LEN_W-1:0]  max_len_r;

  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] abs_sum;
  logic [BYTE_W-1:0] abs_sos;
  logic [LEN_W-1:0]  limit;
  logic              len_ok;
  logic [FILL_W-1:0] fill_inc;

  assign b        = in_item.rx_byte;
  assign abs_sum  = run_sum_r + b;
  assign abs_sos  = sos_r + abs_sum;
  assign limit    = (max_len_r > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : max_len_r;
  assign len_ok   = (b <= {{(BYTE_W-LEN_W){1'b0}}, limit});
  assign fill_inc = fill_r + FILL_W'(1);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      if (in_item.timeout) begin
        phase_nxt = PH_HUNT1;
      end else begin
        case (phase_r)
          PH_HUNT2: phase_nxt = (b == start_two_r) ? PH_ID : PH_HUNT1;
          PH_ID:    phase_nxt = PH_LEN;
          PH_LEN: begin
            if (!len_ok) begin
              phase_nxt = PH_HUNT1;
            end else if (b != '0) begin
              phase_nxt = PH_DATA;
            end else begin
              phase_nxt = PH_CHK1;
            end
          end
          PH_DATA:  phase_nxt = (fill_inc >= len_r) ? PH_CHK1 : PH_DATA;
          PH_CHK1:  phase_nxt = (b == run_sum_r) ? PH_CHK2 : PH_HUNT1;
          PH_CHK2:  phase_nxt = PH_HUNT1;
          default:  phase_nxt = (b == start_one_r) ? PH_HUNT2 : PH_HUNT1;
        endcase
      end
    end
  end

  // Sums, held header, store writes and commits
  always_comb begin
    run_sum_nxt = run_sum_r;
    sos_nxt     = sos_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    fill_nxt    = fill_r;
    bank_nxt    = bank_r;
    wr          = '{en: 1'b0, bank: bank_r, idx: fill_r, data: b};
    push        = 1'b0;
    push_desc   = '{msg_id: id_r, length: len_r};
    if (in_acc && !in_item.timeout) begin
      case (phase_r)
        PH_HUNT2: begin
          run_sum_nxt = abs_sum;
          sos_nxt     = abs_sos;
        end
        PH_ID: begin
          id_nxt      = b;
          run_sum_nxt = abs_sum;
          sos_nxt     = abs_sos;
        end
        PH_LEN: begin
          if (len_ok) begin
            len_nxt     = b[LEN_W-1:0];
            fill_nxt    = '0;
            run_sum_nxt = abs_sum;
            sos_nxt     = abs_sos;
          end
        end
        PH_DATA: begin
          wr.en       = 1'b1;
          fill_nxt    = fill_inc;
          run_sum_nxt = abs_sum;
          sos_nxt     = abs_sos;
        end
        PH_CHK1: begin
          run_sum_nxt = run_sum_r;
        end
        PH_CHK2: begin
          if (b == sos_r) begin
            push     = 1'b1;
            bank_nxt = ~bank_r;
          end
          sos_nxt = '0;
        end
        default: begin
          run_sum_nxt = b;
          sos_nxt     = b;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT1;
      run_sum_r <= '0;
      sos_r     <= '0;
      id_r      <= '0;
      len_r     <= '0;
      fill_r    <= '0;
      bank_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      run_sum_r <= run_sum_nxt;
      sos_r     <= sos_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      fill_r    <= fill_nxt;
      bank_r    <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_one_r <= START_ONE_RST;
      start_two_r <= START_TWO_RST;
      max_len_r   <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_ONE: start_one_r <= cfg_data;
        CFG_START_TWO: start_two_r <= cfg_data;
        CFG_MAX_LEN:   max_len_r   <= cfg_data[LEN_W-1:0];
        default:       start_one_r <= start_one_r;
      endcase
    end
  end

endmodule

[hdl/scpr_back.sv]
module scpr_back
  import scpr_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  scpr_wr_t   wr,
  input  logic       q_valid,
  input  scpr_desc_t q_desc,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output scpr_out_t  out_data
);

  localparam int unsigned LEN_CAP =
    (PAYLOAD_DEPTH < RESULT_CAP) ? PAYLOAD_DEPTH : RESULT_CAP;
  localparam int unsigned AW_IDX  = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;
  localparam int unsigned MEM_DEPTH = NUM_BANKS * (2 ** AW_IDX);

  logic [BYTE_W-1:0] mem [MEM_DEPTH];

  logic              rd_bank_r, rd_bank_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic              s1_v_r, s1_v_nxt;
  scpr_out_t         s1_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              out_v_r, out_v_nxt;
  scpr_out_t         out_r;

  logic              out_take;
  logic              out_load;
  logic              s1_free;
  logic              issue;
  logic              has;
  logic              is_last;
  scpr_out_t         s1_meta;

  assign out_take = out_v_r && !out_stall;
  assign out_load = s1_v_r && (!out_v_r || out_take);
  assign s1_free  = !s1_v_r || out_load;
  assign issue    = q_valid && s1_free;
  assign has      = (q_desc.length != '0);
  assign is_last  = !has || (({1'b0, k_r} + LEN_W'(1)) == q_desc.length);
  assign q_pop    = issue && is_last;

  assign s1_meta = '{msg_id: q_desc.msg_id, length: q_desc.length, data_byte: '0,
                     byte_index: k_r, has_data: has, last: is_last};

  // Advance the replay index; wrap and swap banks on the final byte
  always_comb begin
    k_nxt       = k_r;
    rd_bank_nxt = rd_bank_r;
    if (issue) begin
      if (is_last) begin
        k_nxt       = '0;
        rd_bank_nxt = ~rd_bank_r;
      end else begin
        k_nxt = k_r + IDX_W'(1);
      end
    end
    s1_v_nxt  = issue || (s1_v_r && !out_load);
    out_v_nxt = out_load || (out_v_r && !out_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_bank_r <= 1'b0;
      k_r       <= '0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      rd_bank_r <= rd_bank_nxt;
      k_r       <= k_nxt;
      s1_v_r    <= s1_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.idx[AW_IDX-1:0]}] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[{rd_bank_r, k_r[AW_IDX-1:0]}];
      s1_r      <= s1_meta;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= '{msg_id: s1_r.msg_id, length: s1_r.length,
                 data_byte: s1_r.has_data ? rd_data_r : '0,
                 byte_index: s1_r.byte_index, has_data: s1_r.has_data, last: s1_r.last};
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

[hdl/sum_checked_packet_receiver.sv]
// Packet receiver with a dual-sum check.
//
// Input channel (in_valid / in_stall / in_data): one link byte per transfer,
// or a transfer with timeout set, which drops any partial packet and returns
// the parser to hunting for start byte one. A packet is start one, start two,
// id, length, payload, running-sum byte, sum-of-sums byte.
// Result channel (out_valid / out_stall / out_data): a good packet comes out
// as one transfer per payload byte, in order, last set on the final one; an
// empty packet gives a single transfer with has_data clear.
// Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; write only while the block is idle.
// Throughput: one input byte per cycle and, while out_stall is low, one result
// per cycle. The payload store has two banks, so input stalls only while two
// good packets both wait to be replayed (descriptor queue full).
// Path: after the edge that takes its last check byte, the first result of a
// packet passes the descriptor queue, the store read register and the output
// register, in that order.
// Reset (rst_n low, synchronous): parser hunts, queue and output empty,
// configuration back to its defaults; no clearing pass is needed.
// A stalled result holds on out_data; replay and the store read pause behind it.
module sum_checked_packet_receiver
  import scpr_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scpr_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scpr_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  logic       in_acc;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       push;
  scpr_desc_t push_desc;
  scpr_desc_t head_desc;
  scpr_wr_t   wr;

  // Hold input while both payload banks are owned by waiting packets
  assign in_stall  = q_full;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  scpr_front #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_item   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .push      (push),
    .push_desc (push_desc)
  );

  // Descriptors of packets that passed both checks, one per store bank
  scpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head_desc (head_desc),
    .not_empty (q_valid),
    .full      (q_full)
  );

  scpr_back #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .q_valid   (q_valid),
    .q_desc    (head_desc),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hdl/scpr_checker.sv]
`include "sum_checked_packet_receiver_assert.svh"

module scpr_checker
  import scpr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input scpr_out_t out_data
);

  logic                     out_held;
  logic                     out_empty;
  logic                     out_full;
  logic                     out_mid;
  logic                     empty_ok;
  logic                     index_ok;
  logic                     run_ok;
  logic [$bits(scpr_out_t):0] out_word;
  logic [BYTE_W-1:0]        prev_id_r;
  logic [IDX_W-1:0]         prev_idx_r;

  assign out_word  = {out_valid, out_data};
  assign out_held  = out_valid && out_stall;
  assign out_empty = out_valid && !out_data.has_data;
  assign out_full  = out_valid && out_data.has_data;
  assign out_mid   = out_valid && !out_stall && !out_data.last;
  assign empty_ok  = out_data.last && (out_data.length == '0) && (out_data.data_byte == '0) &&
                     (out_data.byte_index == '0);
  assign index_ok  = ({1'b0, out_data.byte_index} < out_data.length) &&
                     (out_data.last == (({1'b0, out_data.byte_index} + 6'd1) == out_data.length));
  assign run_ok    = (out_data.msg_id == prev_id_r) &&
                     (out_data.byte_index == prev_idx_r + 5'd1);

  // Hold last cycle's id and index
  always_ff @(posedge clk) begin
    prev_id_r  <= out_data.msg_id;
    prev_idx_r <= out_data.byte_index;
  end

  `SCPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, $stable(out_word), "stalled result moved")

  `SCPR_ASSERT_IMPL(a_empty_pkt, clk, rst_n, out_empty, empty_ok, "bad empty result")

  `SCPR_ASSERT_IMPL(a_index_last, clk, rst_n, out_full, index_ok, "index or last flag off")

  `SCPR_ASSERT_NEXT(a_run_order, clk, rst_n, out_mid, !out_valid || run_ok, "payload run broken")

endmodule

bind sum_checked_packet_receiver scpr_checker u_scpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[test/tb_sum_checked_packet_receiver.sv]
`timescale 1ns / 100ps

module tb_sum_checked_packet_receiver;
  import scpr_pkg::*;

  localparam int unsigned STORE_DEPTH = 32;
  // Cycles to let pass once nothing is due: covers the two-stage replay pipe
  localparam int unsigned DRAIN_HOLD  = 10;
  // Cycles without any transfer before the run is abandoned
  localparam int unsigned QUIET_LIMIT = 2000;
  // Register index past the last real register; writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {
    FLAW_NONE,
    FLAW_START_TWO,
    FLAW_LENGTH,
    FLAW_SUM,
    FLAW_SOS,
    FLAW_TIMEOUT
  } packet_flaw_t;

  // Tracks the parser and the two check sums, and holds the payload runs that
  // good packets must replay, oldest first.
  class packet_replay_check_t;
    logic [BYTE_W-1:0] start_one;
    logic [BYTE_W-1:0] start_two;
    logic [LEN_W-1:0]  max_len;
    scpr_phase_t       stage;
    logic [BYTE_W-1:0] run_sum;
    logic [BYTE_W-1:0] sum_sums;
    logic [BYTE_W-1:0] held_id;
    logic [LEN_W-1:0]  held_len;
    logic [LEN_W-1:0]  fill_idx;
    logic [BYTE_W-1:0] store [STORE_DEPTH];
    scpr_out_t         replay_due [$];
    int unsigned       fails;

    function new();
      start_one = START_ONE_RST;
      start_two = START_TWO_RST;
      max_len   = MAX_LEN_RST;
      stage     = PH_HUNT1;
      run_sum   = '0;
      sum_sums  = '0;
      held_id   = '0;
      held_len  = '0;
      fill_idx  = '0;
      fails     = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
      case (idx)
        CFG_START_ONE: start_one = value;
        CFG_START_TWO: start_two = value;
        CFG_MAX_LEN:   max_len = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Largest length byte that starts a payload
    function int unsigned length_cap();
      int unsigned lim;
      lim = max_len;
      if (lim > STORE_DEPTH) lim = STORE_DEPTH;
      if (lim > RESULT_CAP) lim = RESULT_CAP;
      return lim;
    endfunction

    function void fold_in(logic [BYTE_W-1:0] b);
      run_sum  = run_sum + b;
      sum_sums = sum_sums + run_sum;
    endfunction

    // Advance the parser by one accepted transfer; queue the replay of a good packet
    function void note_byte(scpr_in_t item);
      logic [BYTE_W-1:0] b;
      scpr_out_t         rec;
      int                k;
      b = item.rx_byte;
      if (item.timeout) begin
        stage = PH_HUNT1;
        return;
      end
      case (stage)
        PH_HUNT2: begin
          fold_in(b);
          stage = (b == start_two) ? PH_ID : PH_HUNT1;
        end
        PH_ID: begin
          held_id = b;
          fold_in(b);
          stage = PH_LEN;
        end
        PH_LEN: begin
          if (b <= length_cap()) begin
            held_len = b[LEN_W-1:0];
            fill_idx = '0;
            fold_in(b);
            stage = (b != 0) ? PH_DATA : PH_CHK1;
          end else begin
            stage = PH_HUNT1;
          end
        end
        PH_DATA: begin
          if (fill_idx < STORE_DEPTH) store[fill_idx] = b;
          fill_idx = fill_idx + 1'b1;
          fold_in(b);
          if (fill_idx >= held_len) stage = PH_CHK1;
        end
        PH_CHK1: begin
          stage = (b == run_sum) ? PH_CHK2 : PH_HUNT1;
        end
        PH_CHK2: begin
          if (b == sum_sums) begin
            if (held_len == 0) begin
              rec = '0;
              rec.msg_id = held_id;
              rec.last = 1'b1;
              replay_due.push_back(rec);
            end else begin
              for (k = 0; k < held_len && k < RESULT_CAP && k < STORE_DEPTH; k++) begin
                rec.msg_id     = held_id;
                rec.length     = held_len;
                rec.data_byte  = store[k];
                rec.byte_index = k[IDX_W-1:0];
                rec.has_data   = 1'b1;
                rec.last       = (k + 1 == held_len);
                replay_due.push_back(rec);
              end
            end
          end
          sum_sums = '0;
          stage = PH_HUNT1;
        end
        default: begin
          stage = (b == start_one) ? PH_HUNT2 : PH_HUNT1;
          run_sum  = b;
          sum_sums = b;
        end
      endcase
    endfunction

    function void flag(string field, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      fails++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(scpr_out_t got);
      scpr_out_t want;
      if (replay_due.size() == 0) begin
        fails++;
        $display("%0t: result %h with nothing due", $time, got);
        return;
      end
      want = replay_due.pop_front();
      if (got.msg_id !== want.msg_id) flag("msg_id", want.msg_id, got.msg_id);
      if (got.length !== want.length) flag("length", want.length, got.length);
      if (got.data_byte !== want.data_byte) flag("data_byte", want.data_byte, got.data_byte);
      if (got.byte_index !== want.byte_index)
        flag("byte_index", want.byte_index, got.byte_index);
      if (got.has_data !== want.has_data) flag("has_data", want.has_data, got.has_data);
      if (got.last !== want.last) flag("last", want.last, got.last);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  scpr_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  scpr_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  packet_replay_check_t board = new();
  bit                   calm = 1'b0;   // set: neither side idles
  int unsigned          sent_bytes = 0;
  int unsigned          quiet_cycles = 0;

  sum_checked_packet_receiver #(
    .PAYLOAD_DEPTH(STORE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: check each transfer against the oldest due result, then
  // decide the stall for the next cycle. Values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (out_valid && !out_stall) board.check_result(out_data);
    out_stall <= !calm && ($urandom_range(99) < 6);
  end

  // Watchdog: give up when no channel has moved a transfer for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item, with an occasional idle gap first, and hold it until
  // the block takes the transfer. in_valid stays high afterwards; the next
  // call lowers it only for an idle gap, and a drain lowers it.
  task automatic send_item(input scpr_in_t item);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    board.note_byte(item);
    sent_bytes++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    scpr_in_t item;
    item.rx_byte = b;
    item.timeout = 1'b0;
    send_item(item);
  endtask

  // A timeout marker carries a junk byte that the block must ignore
  task automatic send_timeout();
    scpr_in_t item;
    item.rx_byte = 8'($urandom);
    item.timeout = 1'b1;
    send_item(item);
  endtask

  // Build a frame under the current start bytes, spoil it as asked, send it.
  // fill below zero gives a random payload.
  task automatic send_packet(input logic [BYTE_W-1:0] id, input int unsigned len,
                             input packet_flaw_t flaw, input int fill);
    logic [BYTE_W-1:0] frame [$];
    logic [BYTE_W-1:0] run;
    logic [BYTE_W-1:0] sos;
    int                cut;
    frame.push_back(board.start_one);
    frame.push_back(board.start_two);
    if (flaw == FLAW_START_TWO) begin
      // Often the wrong byte is start one itself, which must not restart the hunt
      frame[1] = $urandom_range(1) ? board.start_one : 8'($urandom);
      if (frame[1] == board.start_two) frame[1] = board.start_two ^ 8'h01;
    end
    frame.push_back(id);
    if (flaw == FLAW_LENGTH) begin
      frame.push_back(8'($urandom_range(255, board.length_cap() + 1)));
      foreach (frame[i]) send_byte(frame[i]);
      return;
    end
    frame.push_back(8'(len));
    repeat (len) frame.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    run = '0;
    sos = '0;
    foreach (frame[i]) begin
      run = run + frame[i];
      sos = sos + run;
    end
    frame.push_back(run ^ ((flaw == FLAW_SUM) ? 8'($urandom_range(255, 1)) : 8'h00));
    frame.push_back(sos ^ ((flaw == FLAW_SOS) ? 8'($urandom_range(255, 1)) : 8'h00));
    cut = (flaw == FLAW_TIMEOUT) ? $urandom_range(frame.size() - 1, 1) : -1;
    foreach (frame[i]) begin
      if (i == cut) send_timeout();
      send_byte(frame[i]);
    end
  endtask

  // Mostly well-formed packets with random content, salted with stray bytes,
  // timeouts and spoilt frames. big_pct is the share of maximum-length packets.
  task automatic random_traffic(input int unsigned n_bytes, input int unsigned big_pct);
    int unsigned first;
    int unsigned roll;
    int unsigned cap;
    int unsigned len;
    packet_flaw_t flaw;
    first = sent_bytes;
    while (sent_bytes - first < n_bytes) begin
      roll = $urandom_range(99);
      cap  = board.length_cap();
      if (roll < 10) begin
        send_byte($urandom_range(99) < 40 ? board.start_one : 8'($urandom));
      end else if (roll < 14) begin
        send_timeout();
      end else begin
        if (cap != 0 && $urandom_range(99) < big_pct) len = cap;
        else len = $urandom_range((cap < 6) ? cap : 6, 0);
        flaw = ($urandom_range(99) < 75) ? FLAW_NONE :
               packet_flaw_t'($urandom_range(FLAW_TIMEOUT, FLAW_START_TWO));
        send_packet(8'($urandom), len, flaw, -1);
      end
    end
  endtask

  // Drop valid and hold off until every due result has arrived, then give
  // the block time to finish anything that produces no result.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.replay_due.size() != 0) @(posedge clk);
    repeat (DRAIN_HOLD) @(posedge clk);
  endtask

  // Write all three registers back to back, optionally poking the unused index
  task automatic apply_settings(input logic [BYTE_W-1:0] one, input logic [BYTE_W-1:0] two,
                                input logic [BYTE_W-1:0] max_data, input bit poke_unused);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [BYTE_W-1:0]    val [4];
    idx = '{CFG_START_ONE, CFG_UNUSED, CFG_START_TWO, CFG_MAX_LEN};
    val = '{one, 8'($urandom), two, max_data};
    foreach (idx[i]) begin
      if (idx[i] == CFG_UNUSED && !poke_unused) continue;
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      board.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [BYTE_W-1:0] pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings
    send_packet(8'h00, 0, FLAW_NONE, 0);      // empty packet, all-zero id and length
    send_byte(board.start_one);               // stray start one: the next frame's
    send_packet(8'h3c, 1, FLAW_NONE, -1);     // own start one is a bad second byte
    send_byte(board.start_one);               // timeout cuts a frame short
    send_timeout();
    send_packet(8'h11, 0, FLAW_LENGTH, -1);   // length over the limit
    send_packet(8'hff, 1, FLAW_NONE, 8'hff);  // all-ones id and payload
    random_traffic(30, 5);
    drain();

    // Smallest limit: only empty packets get through
    apply_settings(8'h00, 8'hff, 8'h00, 1'b0);
    random_traffic(25, 0);
    drain();

    // Limit written as all ones acts as the full store; replay a full packet
    apply_settings(8'hff, 8'h00, 8'hff, 1'b0);
    send_packet(8'($urandom), board.length_cap(), FLAW_NONE, -1);
    random_traffic(25, 8);
    drain();                                  // sender holds until all is replayed
    random_traffic(25, 8);
    drain();

    // Random settings, a dropped write to the unused index, no idling at all
    calm = 1'b1;
    apply_settings(8'($urandom), 8'($urandom), 8'($urandom_range(32)), 1'b1);
    random_traffic(35, 5);
    drain();
    calm = 1'b0;

    // Both start bytes equal
    pick = 8'($urandom);
    apply_settings(pick, pick, 8'd32, 1'b1);
    random_traffic(25, 5);
    drain();

    if (board.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
